FILE: design/sdcd_pkg.sv
`default_nettype none

package sdcd_pkg;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH,
      ST_RESPOND
   } state_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_BASE_CLOCK = 2'd0,
      REG_SPEC_V3    = 2'd1,
      REG_PROG_MODE  = 2'd2
   } reg_index_type;

   localparam int          TARGET_W     = 32;
   localparam int          FIELD_W      = 10;
   localparam int          STEP_CNT_W   = 5;   // 32 quotient bits, one per step
   localparam logic [31:0] HS_LIMIT_HZ  = 32'd26000000;
   localparam logic [31:0] BASE_RESET   = 32'd50000000;

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture target, load base into quotient, clear remainder
      logic step;     // one restoring divide step
      logic finish;   // map quotient to divider field
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_step;
   } status_type;

endpackage

`default_nettype wire

FILE: design/sd_host_clock_divisor_select_top.sv
`default_nettype none

// SD host clock divisor select: 32 steps of a one-bit restoring divider,
// a field mapping step, then a one-cycle result strobe.
// One transaction at a time; a new start is taken in the strobe cycle.
// The receiver cannot stall. Reset (synchronous) returns to idle
// and loads base 50 MHz, v3 rules, divided mode.
module sd_host_clock_divisor_select_top #(
   parameter int PROG_MAX_DIV = 1024,
   parameter int DIV10_MAX    = 2046,
   parameter int DIV8_MAX     = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request transaction
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_target_hz,
   // response transaction, one-cycle strobe
   output logic             rsp_valid,
   output logic [9:0]       rsp_divider_field,
   output logic             rsp_generator_select,
   output logic             rsp_high_speed,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   sdcd_pkg::cmd_type    cmd;
   sdcd_pkg::status_type status;
   logic                 accept;

   // Accept a transaction only when not busy
   assign accept    = start & ~busy;
   // Registers must be changed only between transactions; the block does not enforce this and csr_ready is held high
   assign csr_ready = 1'b1;

   sdcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sdcd_datapath #(
      .PROG_MAX_DIV (PROG_MAX_DIV),
      .DIV10_MAX    (DIV10_MAX),
      .DIV8_MAX     (DIV8_MAX)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .target_hz        (req_target_hz),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .divider_field    (rsp_divider_field),
      .generator_select (rsp_generator_select),
      .high_speed       (rsp_high_speed)
   );

endmodule

`default_nettype wire

FILE: design/sdcd_ctrl.sv
`default_nettype none

module sdcd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire sdcd_pkg::status_type status,
   output sdcd_pkg::cmd_type       cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   sdcd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdcd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdcd_pkg::ST_IDLE: begin
            if (start) state_in = sdcd_pkg::ST_DIVIDE;
         end
         sdcd_pkg::ST_DIVIDE: begin
            if (status.last_step) state_in = sdcd_pkg::ST_FINISH;
         end
         sdcd_pkg::ST_FINISH: begin
            state_in = sdcd_pkg::ST_RESPOND;
         end
         sdcd_pkg::ST_RESPOND: begin
            state_in = start ? sdcd_pkg::ST_DIVIDE : sdcd_pkg::ST_IDLE;
         end
         default: begin
            state_in = sdcd_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         sdcd_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         sdcd_pkg::ST_DIVIDE: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
         end
         sdcd_pkg::ST_FINISH: begin
            busy       = 1'b1;
            cmd.finish = 1'b1;
         end
         sdcd_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            cmd.load  = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/sdcd_datapath.sv
`default_nettype none

module sdcd_datapath #(
   parameter int PROG_MAX_DIV = 1024,
   parameter int DIV10_MAX    = 2046,
   parameter int DIV8_MAX     = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sdcd_pkg::cmd_type                  cmd,
   output sdcd_pkg::status_type                    status,
   input  wire logic [sdcd_pkg::TARGET_W-1:0]      target_hz,
   input  wire logic                               csr_write,
   input  wire logic [1:0]                         csr_index,
   input  wire logic [31:0]                        csr_data,
   output logic [sdcd_pkg::FIELD_W-1:0]            divider_field,
   output logic                                    generator_select,
   output logic                                    high_speed
);

   localparam int NPOW = $clog2(DIV8_MAX + 1);   // powers of two 1..DIV8_MAX
   localparam logic [31:0] PROG_LIM = 32'(PROG_MAX_DIV);
   localparam logic [31:0] DIV10_HALF = 32'(DIV10_MAX / 2);

   // Configuration registers
   logic [31:0] base_ff;
   logic        spec_v3_ff;
   logic        prog_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= sdcd_pkg::BASE_RESET;
         spec_v3_ff   <= 1'b1;
         prog_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            sdcd_pkg::REG_BASE_CLOCK: base_ff      <= csr_data;
            sdcd_pkg::REG_SPEC_V3:    spec_v3_ff   <= csr_data[0];
            sdcd_pkg::REG_PROG_MODE:  prog_mode_ff <= csr_data[0];
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end
   end

   // Restoring divider: base / (target + 1)
   logic [32:0]                     divisor_ff;
   logic [31:0]                     quo_ff, quo_in;
   logic [32:0]                     rem_ff, rem_in;
   logic [sdcd_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic [33:0]                     trial;
   logic [33:0]                     diff;

   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      if (!diff[33]) begin
         rem_in = diff[32:0];
         quo_in = {quo_ff[30:0], 1'b1};
      end else begin
         rem_in = trial[32:0];
         quo_in = {quo_ff[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         divisor_ff <= {1'b0, target_hz} + 33'd1;
         quo_ff     <= base_ff;
         rem_ff     <= '0;
         high_speed <= (target_hz > sdcd_pkg::HS_LIMIT_HZ);
      end else if (cmd.step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '1;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff - sdcd_pkg::STEP_CNT_W'(1);
      end
   end

   assign status.last_step = (cnt_ff == '0);

   // Map the quotient q (smallest divisor is q+1) to the field
   logic [sdcd_pkg::FIELD_W-1:0] prog_field;
   logic [sdcd_pkg::FIELD_W-1:0] v3_field;
   logic [sdcd_pkg::FIELD_W-1:0] v2_field;
   logic [sdcd_pkg::FIELD_W-1:0] field_in;
   logic [31:0]                  half;

   assign half = {1'b0, quo_ff[31:1]} + 32'd1;   // (smallest even d) / 2

   always_comb begin
      prog_field = (quo_ff < PROG_LIM) ? quo_ff[sdcd_pkg::FIELD_W-1:0]
                                       : sdcd_pkg::FIELD_W'(PROG_MAX_DIV - 1);
      if (quo_ff == '0) begin
         v3_field = '0;
      end else if (half <= DIV10_HALF) begin
         v3_field = half[sdcd_pkg::FIELD_W-1:0];
      end else begin
         v3_field = DIV10_HALF[sdcd_pkg::FIELD_W-1:0];
      end
      // Smallest power of two above q, else the largest allowed
      v2_field = sdcd_pkg::FIELD_W'((1 << (NPOW - 1)) >> 1);
      for (int k = NPOW - 1; k >= 0; k--) begin
         if (quo_ff < 32'(1 << k)) v2_field = sdcd_pkg::FIELD_W'((1 << k) >> 1);
      end
      if (spec_v3_ff && prog_mode_ff) begin
         field_in = prog_field;
      end else if (spec_v3_ff) begin
         field_in = v3_field;
      end else begin
         field_in = v2_field;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         divider_field    <= field_in;
         generator_select <= spec_v3_ff & prog_mode_ff;
      end
   end

endmodule

`default_nettype wire
